// File: src/euler_pose_pinhole_projection_unit_assert.svh
// Assertion macros for the pinhole projection unit.
// Used by the top level; expects clk and rst in scope.
`ifndef EULER_POSE_PINHOLE_PROJECTION_UNIT_ASSERT_SVH
`define EULER_POSE_PINHOLE_PROJECTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define EPPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EPPU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EPPU_ASSERT(lbl, prop, msg)
`define EPPU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: src/eppu_pkg.sv
// Shared types and constants of the pinhole projection unit.
// No dependencies.
package eppu_pkg;

  localparam int NREG    = 8;
  localparam int IW      = 3;
  localparam int FB      = 16;
  localparam int UW      = 51;
  localparam int QB      = 2 * FB - 1;
  localparam int XF_LAT  = 13;
  localparam int LAT     = XF_LAT + QB + 2;
  localparam int NS      = 6;

  localparam logic [15:0] QUARTER = 16'd16384;
  localparam logic signed [31:0] SIN_C [NS] = '{
    32'sd3864, 32'sd172272, 32'sd5026995, 32'sd85569306, 32'sd693598668, 32'sd1686629713
  };
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               zero_depth;
  } out_t;

  typedef logic [NREG-1:0][31:0] kmat_t;

  // k21 k20 k12 k11 k10 k02 k01 k00
  localparam kmat_t K_RESET = {32'd0, 32'd0, 32'd0, 32'd65536,
                               32'd0, 32'd0, 32'd0, 32'd65536};

  typedef struct packed {
    logic signed [UW-1:0] u0;
    logic signed [UW-1:0] u1;
    logic signed [UW-1:0] u2;
  } hom_t;

  typedef struct packed {
    logic [UW-1:0] rem;
    logic [UW-1:0] den;
    logic [QB-1:0] dvd;
    logic [QB-1:0] quo;
  } div_t;

endpackage

// File: src/eppu_sine.sv
// Pipelined fixed-point sine of a 16-bit binary angle, Q2.30 result.
// Depends on eppu_pkg.
module eppu_sine import eppu_pkg::*; (
  input  logic               clk,
  input  logic [15:0]        angle,
  output logic signed [31:0] sine
);

  logic [1:0]  quad;
  logic [14:0] r;
  logic [29:0] rsq;

  logic [14:0]        rs  [NS];
  logic               ng  [NS];
  logic [30:0]        z2  [NS-1];
  logic signed [31:0] acc [1:NS-1];

  logic signed [63:0] fprod;
  logic signed [33:0] fval;
  logic signed [33:0] fclamp;

  always_comb begin
    quad = angle[15:14];
    // fold odd quadrants onto the rising edge
    r    = quad[0] ? 15'(QUARTER[14:0] - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    rsq  = r * r;
  end

  always_ff @(posedge clk) begin
    rs[0] <= r;
    ng[0] <= quad[1];
    z2[0] <= {rsq[28:0], 2'b00};
  end

  for (genvar k = 1; k < NS; k++) begin : g_poly
    logic signed [31:0] prev;
    logic signed [63:0] prod;
    if (k == 1) begin : g_first
      assign prev = SIN_C[0];
    end else begin : g_rest
      assign prev = acc[k-1];
    end
    assign prod = prev * $signed({1'b0, z2[k-1]});
    always_ff @(posedge clk) begin
      acc[k] <= SIN_C[k] - prod[61:30];
      rs[k]  <= rs[k-1];
      ng[k]  <= ng[k-1];
    end
    if (k < NS - 1) begin : g_z2
      always_ff @(posedge clk) begin
        z2[k] <= z2[k-1];
      end
    end
  end

  always_comb begin
    fprod  = acc[NS-1] * $signed({1'b0, rs[NS-1], 16'b0});
    fval   = fprod[63:30];
    fclamp = (fval > ONE_Q30) ? ONE_Q30 : fval;
  end

  always_ff @(posedge clk) begin
    sine <= ng[NS-1] ? 32'(-fclamp) : 32'(fclamp);
  end

endmodule

// File: src/eppu_xform.sv
// Rotation build, rigid transform and intrinsic product of the projection unit.
// Depends on eppu_pkg and eppu_sine.
module eppu_xform import eppu_pkg::*; (
  input  logic  clk,
  input  in_t   item,
  input  kmat_t k,
  output hom_t  hom
);

  localparam int DL = 10;

  typedef struct packed {
    logic signed [31:0] tx, ty, tz, px, py, pz;
  } tp_t;

  function automatic logic signed [31:0] mul30(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[61:30];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'h7fffffff;
    if (v < -37'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  logic signed [31:0] sx, cx, sy, cy, sz, cz;

  eppu_sine u_sx (.clk, .angle(item.roll),            .sine(sx));
  eppu_sine u_cx (.clk, .angle(item.roll + QUARTER),  .sine(cx));
  eppu_sine u_sy (.clk, .angle(item.pitch),           .sine(sy));
  eppu_sine u_cy (.clk, .angle(item.pitch + QUARTER), .sine(cy));
  eppu_sine u_sz (.clk, .angle(item.yaw),             .sine(sz));
  eppu_sine u_cz (.clk, .angle(item.yaw + QUARTER),   .sine(cz));

  // carry translation and point alongside the sine pipelines
  tp_t dl [DL];
  always_ff @(posedge clk) begin
    dl[0] <= {item.cam_x, item.cam_y, item.cam_z, item.point_x, item.point_y, item.point_z};
    for (int i = 1; i < DL; i++) dl[i] <= dl[i-1];
  end

  logic signed [31:0] a_r00, a_r10, a_r21, a_r22;
  logic signed [32:0] a_r20;
  logic signed [31:0] a_sxsy, a_cxsy, a_cxsz, a_sxsz, a_cxcz, a_sxcz, a_cz, a_sz;

  always_ff @(posedge clk) begin
    a_r00  <= mul30(cy, cz);
    a_r10  <= mul30(cy, sz);
    a_r20  <= -33'(sy);
    a_r21  <= mul30(sx, cy);
    a_r22  <= mul30(cx, cy);
    a_sxsy <= mul30(sx, sy);
    a_cxsy <= mul30(cx, sy);
    a_cxsz <= mul30(cx, sz);
    a_sxsz <= mul30(sx, sz);
    a_cxcz <= mul30(cx, cz);
    a_sxcz <= mul30(sx, cz);
    a_cz   <= cz;
    a_sz   <= sz;
  end

  logic signed [32:0] rm [3][3];
  always_ff @(posedge clk) begin
    rm[0][0] <= 33'(a_r00);
    rm[1][0] <= 33'(a_r10);
    rm[2][0] <= a_r20;
    rm[0][1] <= 33'(mul30(a_sxsy, a_cz)) - 33'(a_cxsz);
    rm[1][1] <= 33'(mul30(a_sxsy, a_sz)) + 33'(a_cxcz);
    rm[2][1] <= 33'(a_r21);
    rm[0][2] <= 33'(mul30(a_cxsy, a_cz)) + 33'(a_sxsz);
    rm[1][2] <= 33'(mul30(a_cxsy, a_sz)) - 33'(a_sxcz);
    rm[2][2] <= 33'(a_r22);
  end

  logic signed [31:0] pv [3];
  logic signed [31:0] tv [3];
  always_comb begin
    pv[0] = dl[DL-2].px;
    pv[1] = dl[DL-2].py;
    pv[2] = dl[DL-2].pz;
    tv[0] = dl[DL-1].tx;
    tv[1] = dl[DL-1].ty;
    tv[2] = dl[DL-1].tz;
  end

  logic signed [64:0] cprod [3][3];
  logic signed [34:0] c     [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) cprod[i][j] = rm[i][j] * pv[j];
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) c[i][j] <= cprod[i][j][64:30];
  end

  logic signed [31:0] x [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      x[i] <= sat32(37'(tv[i]) + 37'(c[i][0]) + 37'(c[i][1]) + 37'(c[i][2]));
  end

  logic signed [63:0] eprod [3][3];
  logic signed [47:0] e     [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        eprod[i][j] = (i == 2 && j == 2) ? 64'sd0 : $signed(k[3*i+j]) * x[j];
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] <= (i == 2 && j == 2) ? 48'(x[2]) : eprod[i][j][63:16];
  end

  always_ff @(posedge clk) begin
    hom.u0 <= UW'(e[0][0]) + UW'(e[0][1]) + UW'(e[0][2]);
    hom.u1 <= UW'(e[1][0]) + UW'(e[1][1]) + UW'(e[1][2]);
    hom.u2 <= UW'(e[2][0]) + UW'(e[2][1]) + UW'(e[2][2]);
  end

endmodule

// File: src/eppu_div_cell.sv
// One restoring-division cell: one quotient bit per cell, registered.
// Depends on eppu_pkg.
module eppu_div_cell import eppu_pkg::*; (
  input  logic clk,
  input  div_t din,
  output div_t dout
);

  logic [UW:0] trial;
  logic [UW:0] diff;
  logic        take;

  always_comb begin
    trial = {din.rem, din.dvd[QB-1]};
    diff  = trial - {1'b0, din.den};
    take  = trial >= {1'b0, din.den};
  end

  always_ff @(posedge clk) begin
    dout.rem <= take ? diff[UW-1:0] : trial[UW-1:0];
    dout.den <= din.den;
    dout.dvd <= {din.dvd[QB-2:0], 1'b0};
    dout.quo <= {din.quo[QB-2:0], take};
  end

endmodule

// File: src/euler_pose_pinhole_projection_unit.sv
// Euler-pose pinhole projection unit, top level.
// Depends on eppu_pkg, eppu_xform, eppu_div_cell and the assertion header.
//
// Usage: drive item and raise start; the item transfers at a rising edge with
// start high and busy low. busy is low except during reset, so one item may
// transfer in every cycle. Each item gives one result on result, marked by
// done for exactly one cycle; results leave in transfer order. The receiver
// cannot stall, and none is needed. Path: the sine pipelines, the rotation,
// transform and intrinsic product, a divide setup register, 31 division
// cells (one quotient bit each) and one output register. Throughput: one
// item per cycle outside reset.
// Configuration: cfg_we writes cfg_data into intrinsic register cfg_index
// (k00 k01 k02 k10 k11 k12 k20 k21) at once; write only with no item in
// flight. Reset (rst, synchronous) drops all items in flight and loads
// k00 = k11 = 1.0, others 0.
`include "euler_pose_pinhole_projection_unit_assert.svh"
module euler_pose_pinhole_projection_unit import eppu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  in_t           item,
  output logic          done,
  output out_t          result,
  input  logic          cfg_we,
  input  logic [IW-1:0] cfg_index,
  input  logic [31:0]   cfg_data
);

  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic ovf_u;
    logic ovf_v;
    logic zero;
  } flag_t;

  kmat_t k;
  hom_t  hom;
  logic  vld [LAT];

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= K_RESET;
    end else if (cfg_we) begin
      k[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  eppu_xform u_xform (.clk, .item, .k, .hom);

  // divide setup: magnitudes, signs, quotient overflow and zero depth
  logic [UW-1:0] un_u, un_v, ud;
  always_comb begin
    un_u = hom.u0[UW-1] ? UW'(-hom.u0) : UW'(hom.u0);
    un_v = hom.u1[UW-1] ? UW'(-hom.u1) : UW'(hom.u1);
    ud   = hom.u2[UW-1] ? UW'(-hom.u2) : UW'(hom.u2);
  end

  div_t  cu [QB+1];
  div_t  cv [QB+1];
  flag_t fl [QB+1];

  always_ff @(posedge clk) begin
    cu[0].rem <= un_u >> (FB - 1);
    cu[0].den <= ud;
    cu[0].dvd <= {un_u[FB-2:0], FB'(0)};
    cu[0].quo <= '0;
    cv[0].rem <= un_v >> (FB - 1);
    cv[0].den <= ud;
    cv[0].dvd <= {un_v[FB-2:0], FB'(0)};
    cv[0].quo <= '0;
    fl[0].neg_u <= hom.u0[UW-1] ^ hom.u2[UW-1];
    fl[0].neg_v <= hom.u1[UW-1] ^ hom.u2[UW-1];
    fl[0].ovf_u <= (un_u >> (FB - 1)) >= ud;
    fl[0].ovf_v <= (un_v >> (FB - 1)) >= ud;
    fl[0].zero  <= (hom.u2 == '0);
    for (int i = 1; i <= QB; i++) fl[i] <= fl[i-1];
  end

  for (genvar g = 0; g < QB; g++) begin : g_cell
    eppu_div_cell u_cell_u (.clk, .din(cu[g]), .dout(cu[g+1]));
    eppu_div_cell u_cell_v (.clk, .din(cv[g]), .dout(cv[g+1]));
  end

  function automatic logic signed [31:0] finish(logic [QB-1:0] q, logic neg, logic ovf);
    if (ovf) return neg ? 32'h80000000 : 32'h7fffffff;
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  always_ff @(posedge clk) begin
    if (fl[QB].zero) begin
      result.pixel_u <= '0;
      result.pixel_v <= '0;
    end else begin
      result.pixel_u <= finish(cu[QB].quo, fl[QB].neg_u, fl[QB].ovf_u);
      result.pixel_v <= finish(cv[QB].quo, fl[QB].neg_v, fl[QB].ovf_v);
    end
    result.zero_depth <= fl[QB].zero;
  end

  assign done = vld[LAT-1];

  `EPPU_ASSERT(a_latency, (start && !busy) |-> ##LAT done, "result missing after transfer")
  `EPPU_ASSERT(a_zero_out, (done && result.zero_depth) |-> (result.pixel_u == 0 && result.pixel_v == 0), "zero depth with nonzero pixel")
  `EPPU_ASSERT_RST(a_reset_flush, $past(rst) |-> !done, "result right after reset")

endmodule
